// ===== src/ttq_pkg.sv =====
// Shared types and constants for the timed task queue.
`default_nettype none
package ttq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int TAG_BITS_DEF  = 8;
  localparam int REM_BITS      = 5;
  localparam int STATUS_BITS   = 2;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  localparam logic [STATUS_BITS-1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_DROPPED  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_RELEASED = 2'd2;
  localparam logic [STATUS_BITS-1:0] STAT_NONE_DUE = 2'd3;

  // broadcast command to every cell of the chain
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/timed_task_queue_core.sv =====
// Top level of the timed task queue: cell chain, sequencer and result register.
//
// Input channel (in_valid_i/in_ready_o) takes one word: op_i, time_value_i, task_tag_i.
// A schedule word (op 0) inserts task_tag_i with due time time_value_i and
// yields one result: accepted, or dropped when DEPTH entries are held.
// A run word (op 1) releases, earliest first, every entry due strictly before
// time_value_i, one result word per entry, last_o set on the final one; with
// nothing due it yields a single none-due result. Equal due times leave in
// scheduling order.
// The input word is registered first; the sequencer then writes each result
// into the output register. A schedule word or a run word keeps the block
// busy until its last result is written, so no new input word is taken
// before then. The whole row of cells shifts at once on an insert, and the head
// cell releases one entry per cycle while the output register is free.
// A new input word is taken while a finished result still waits in the output
// register. If the receiver stalls, the sequencer holds until the output
// register frees up; nothing is lost.
// Reset empties the queue; no clearing pass is needed.
`default_nettype none
module timed_task_queue_core #(
  parameter int DEPTH     = ttq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = ttq_pkg::TIME_BITS_DEF,
  parameter int TAG_BITS  = ttq_pkg::TAG_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              op_i,
  input  wire  [TIME_BITS-1:0]             time_value_i,
  input  wire  [TAG_BITS-1:0]              task_tag_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [ttq_pkg::STATUS_BITS-1:0]  status_o,
  output logic [TAG_BITS-1:0]              released_tag_o,
  output logic [TIME_BITS-1:0]             released_due_o,
  output logic [ttq_pkg::REM_BITS-1:0]     remaining_o,
  output logic                             last_o
);
  import ttq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state_q, state_d;
  logic                 op_q;
  logic [TIME_BITS-1:0] key_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [CntW-1:0]      count_q, count_d;

  logic                         out_valid_q, out_valid_d;
  logic [STATUS_BITS-1:0]       status_q, status_d;
  logic [TAG_BITS-1:0]          rel_tag_q, rel_tag_d;
  logic [TIME_BITS-1:0]         rel_due_q, rel_due_d;
  logic [REM_BITS-1:0]          rem_q, rem_d;
  logic                         last_q, last_d;
  logic [CntW+REM_BITS-1:0]     rem_ext;

  cell_ctrl_t ctrl;

  logic                 c_valid  [DEPTH];
  logic [TIME_BITS-1:0] c_due    [DEPTH];
  logic [TAG_BITS-1:0]  c_tag    [DEPTH];
  logic                 c_bigger [DEPTH];
  logic                 c_below  [DEPTH];
  logic [DEPTH-1:0]     valid_vec;

  logic in_fire, slot_free, full;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign full       = (count_q == CntW'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 pv, pb, nv;
    logic [TIME_BITS-1:0] pd, nd;
    logic [TAG_BITS-1:0]  pt, nt;

    if (i == 0) begin : g_head
      assign pv = 1'b0;
      assign pb = 1'b0;
      assign pd = '0;
      assign pt = '0;
    end else begin : g_mid
      assign pv = c_valid[i-1];
      assign pb = c_bigger[i-1];
      assign pd = c_due[i-1];
      assign pt = c_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign nv = 1'b0;
      assign nd = '0;
      assign nt = '0;
    end else begin : g_body
      assign nv = c_valid[i+1];
      assign nd = c_due[i+1];
      assign nt = c_tag[i+1];
    end

    ttq_cell #(
      .TIME_BITS (TIME_BITS),
      .TAG_BITS  (TAG_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (key_q),
      .new_tag_i     (tag_q),
      .prev_valid_i  (pv),
      .prev_due_i    (pd),
      .prev_tag_i    (pt),
      .prev_bigger_i (pb),
      .next_valid_i  (nv),
      .next_due_i    (nd),
      .next_tag_i    (nt),
      .valid_o       (c_valid[i]),
      .due_o         (c_due[i]),
      .tag_o         (c_tag[i]),
      .bigger_o      (c_bigger[i]),
      .below_o       (c_below[i])
    );

    assign valid_vec[i] = c_valid[i];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ctrl        = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    rel_tag_d   = rel_tag_q;
    rel_due_d   = rel_due_q;
    last_d      = last_q;
    if (in_fire) begin
      state_d = ST_EXEC;
    end
    if (state_q == ST_EXEC && slot_free) begin
      out_valid_d = 1'b1;
      rel_tag_d   = '0;
      rel_due_d   = '0;
      last_d      = 1'b1;
      state_d     = ST_IDLE;
      if (op_q == OP_SCHEDULE) begin
        if (full) begin
          status_d = STAT_DROPPED;
        end else begin
          status_d = STAT_ACCEPTED;
          ctrl.ins = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end else if (c_below[0]) begin
        // head is due: release it, keep going while the next one is due too
        status_d  = STAT_RELEASED;
        rel_tag_d = c_tag[0];
        rel_due_d = c_due[0];
        ctrl.pop  = 1'b1;
        count_d   = count_q - 1'b1;
        last_d    = !c_below[1];
        if (c_below[1]) begin
          state_d = ST_EXEC;
        end
      end else begin
        status_d = STAT_NONE_DUE;
      end
    end
    rem_ext = {{REM_BITS{1'b0}}, count_d};
    rem_d   = rem_q;
    if (state_q == ST_EXEC && slot_free) begin
      rem_d = rem_ext[REM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_i;
      key_q <= time_value_i;
      tag_q <= task_tag_i;
    end
    status_q  <= status_d;
    rel_tag_q <= rel_tag_d;
    rel_due_q <= rel_due_d;
    rem_q     <= rem_d;
    last_q    <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign released_tag_o = rel_tag_q;
  assign released_due_o = rel_due_q;
  assign remaining_o    = rem_q;
  assign last_o         = last_q;

  // number of occupied cells matches the entry count
  a_count_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("cell valid bits disagree with entry count");

  a_no_insert_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |-> !full)
    else $error("insert issued with a full queue");

  a_pop_needs_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |-> valid_vec[0])
    else $error("pop issued with an empty head cell");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_vec[1] |-> !(c_due[0] > c_due[1]))
    else $error("head cells out of order");

  a_exec_waits_for_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && !slot_free) |=> (state_q == ST_EXEC) && out_valid_q)
    else $error("sequencer advanced while result register was held");

endmodule
`default_nettype wire

// ===== src/ttq_cell.sv =====
// One slot of the sorted queue chain: holds an entry, shifts with its neighbors.
`default_nettype none
module ttq_cell #(
  parameter int TIME_BITS = ttq_pkg::TIME_BITS_DEF,
  parameter int TAG_BITS  = ttq_pkg::TAG_BITS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  ttq_pkg::cell_ctrl_t      ctrl_i,
  input  wire     [TIME_BITS-1:0]  key_i,
  input  wire     [TAG_BITS-1:0]   new_tag_i,
  input  wire                      prev_valid_i,
  input  wire     [TIME_BITS-1:0]  prev_due_i,
  input  wire     [TAG_BITS-1:0]   prev_tag_i,
  input  wire                      prev_bigger_i,
  input  wire                      next_valid_i,
  input  wire     [TIME_BITS-1:0]  next_due_i,
  input  wire     [TAG_BITS-1:0]   next_tag_i,
  output logic                     valid_o,
  output logic    [TIME_BITS-1:0]  due_o,
  output logic    [TAG_BITS-1:0]   tag_o,
  output logic                     bigger_o,
  output logic                     below_o
);
  import ttq_pkg::*;

  logic                 valid_q, valid_d;
  logic [TIME_BITS-1:0] due_q, due_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;

  // empty slots count as later than anything, so equal keys land behind
  assign bigger_o = !valid_q || (due_q > key_i);
  assign below_o  = valid_q && (due_q < key_i);
  assign valid_o  = valid_q;
  assign due_o    = due_q;
  assign tag_o    = tag_q;

  always_comb begin
    valid_d = valid_q;
    due_d   = due_q;
    tag_d   = tag_q;
    if (ctrl_i.ins) begin
      if (prev_bigger_i) begin
        valid_d = prev_valid_i;
        due_d   = prev_due_i;
        tag_d   = prev_tag_i;
      end else if (bigger_o) begin
        valid_d = 1'b1;
        due_d   = key_i;
        tag_d   = new_tag_i;
      end
    end else if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      due_d   = next_due_i;
      tag_d   = next_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    due_q <= due_d;
    tag_q <= tag_d;
  end

endmodule
`default_nettype wire

// ===== sim/ttq_result_checker.sv =====
// Watches both channels of the timed task queue, predicts every result word and compares.
`timescale 1ns / 1ps
module ttq_result_checker (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  input  wire                                  in_ready_i,
  input  wire                                  op_i,
  input  wire  [ttq_pkg::TIME_BITS_DEF-1:0]    time_value_i,
  input  wire  [ttq_pkg::TAG_BITS_DEF-1:0]     task_tag_i,
  input  wire                                  out_valid_i,
  input  wire                                  out_ready_i,
  input  wire  [ttq_pkg::STATUS_BITS-1:0]      status_i,
  input  wire  [ttq_pkg::TAG_BITS_DEF-1:0]     released_tag_i,
  input  wire  [ttq_pkg::TIME_BITS_DEF-1:0]    released_due_i,
  input  wire  [ttq_pkg::REM_BITS-1:0]         remaining_i,
  input  wire                                  last_i,
  output int                                   errors_o,
  output int                                   outstanding_o,
  output int                                   released_o,
  output int                                   dropped_o,
  output int                                   none_due_o
);
  import ttq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int TW    = TIME_BITS_DEF;
  localparam int GW    = TAG_BITS_DEF;

  typedef logic [TW-1:0] due_t;
  typedef logic [GW-1:0] tag_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    tag_t                   tag;
    due_t                   due;
    logic [REM_BITS-1:0]    remaining;
    logic                   last;
  } task_result_t;

  // sorted shadow of the queue, earliest due time at index 0
  due_t         entry_due [DEPTH];
  tag_t         entry_tag [DEPTH];
  int           entry_cnt = 0;
  task_result_t expected_q [$];
  int           err_cnt = 0;
  int           n_released = 0;
  int           n_dropped = 0;
  int           n_none_due = 0;

  initial begin
    errors_o      = 0;
    outstanding_o = 0;
    released_o    = 0;
    dropped_o     = 0;
    none_due_o    = 0;
  end

  task automatic push_result(input logic [STATUS_BITS-1:0] st, input tag_t tg, input due_t du,
                             input int rem, input logic lst);
    task_result_t r;
    r.status    = st;
    r.tag       = tg;
    r.due       = du;
    r.remaining = REM_BITS'(rem);
    r.last      = lst;
    expected_q.push_back(r);
  endtask

  task automatic predict_word(input logic op, input due_t tv, input tag_t tg);
    int pos;
    int n;
    if (op == OP_SCHEDULE) begin
      if (entry_cnt >= DEPTH) begin
        push_result(STAT_DROPPED, '0, '0, entry_cnt, 1'b1);
        n_dropped++;
      end else begin
        // new entry goes behind every entry due at the same time or earlier
        pos = entry_cnt;
        while (pos > 0 && entry_due[pos-1] > tv) begin
          entry_due[pos] = entry_due[pos-1];
          entry_tag[pos] = entry_tag[pos-1];
          pos--;
        end
        entry_due[pos] = tv;
        entry_tag[pos] = tg;
        entry_cnt++;
        push_result(STAT_ACCEPTED, '0, '0, entry_cnt, 1'b1);
      end
    end else begin
      n = 0;
      while (n < entry_cnt && entry_due[n] < tv) n++;
      if (n == 0) begin
        push_result(STAT_NONE_DUE, '0, '0, entry_cnt, 1'b1);
        n_none_due++;
      end else begin
        for (int i = 0; i < n; i++)
          push_result(STAT_RELEASED, entry_tag[i], entry_due[i], entry_cnt - i - 1, i + 1 == n);
        for (int i = n; i < entry_cnt; i++) begin
          entry_due[i-n] = entry_due[i];
          entry_tag[i-n] = entry_tag[i];
        end
        entry_cnt  -= n;
        n_released += n;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [TW-1:0] want,
                             input logic [TW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic compare_result();
    task_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result word with nothing expected: expected none, actual status %0d tag %h due %h remaining %0d last %b",
               $time, status_i, released_tag_i, released_due_i, remaining_i, last_i);
      err_cnt++;
    end else begin
      want = expected_q.pop_front();
      check_field("status", TW'(want.status), TW'(status_i));
      check_field("released_tag", TW'(want.tag), TW'(released_tag_i));
      check_field("released_due", want.due, released_due_i);
      check_field("remaining", TW'(want.remaining), TW'(remaining_i));
      check_field("last", TW'(want.last), TW'(last_i));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      entry_cnt = 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) predict_word(op_i, time_value_i, task_tag_i);
      if (out_valid_i && out_ready_i) compare_result();
    end
    // published through nonblocking assignments so the stimulus side reads a settled value
    outstanding_o <= expected_q.size();
    errors_o      <= err_cnt;
    released_o    <= n_released;
    dropped_o     <= n_dropped;
    none_due_o    <= n_none_due;
  end

endmodule

// ===== sim/tb_timed_task_queue_core.sv =====
// Testbench top for the timed task queue: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_timed_task_queue_core;
  import ttq_pkg::*;

  localparam int TW             = TIME_BITS_DEF;
  localparam int GW             = TAG_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_WORDS   = 300;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   op_i = OP_SCHEDULE;
  logic [TW-1:0]          time_value_i = '0;
  logic [GW-1:0]          task_tag_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [STATUS_BITS-1:0] status_o;
  logic [GW-1:0]          released_tag_o;
  logic [TW-1:0]          released_due_o;
  logic [REM_BITS-1:0]    remaining_o;
  logic                   last_o;

  int errors;
  int outstanding;
  int n_released;
  int n_dropped;
  int n_none_due;
  int words_sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  timed_task_queue_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .time_value_i   (time_value_i),
    .task_tag_i     (task_tag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .released_tag_o (released_tag_o),
    .released_due_o (released_due_o),
    .remaining_o    (remaining_o),
    .last_o         (last_o)
  );

  ttq_result_checker u_result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .op_i           (op_i),
    .time_value_i   (time_value_i),
    .task_tag_i     (task_tag_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .released_tag_i (released_tag_o),
    .released_due_i (released_due_o),
    .remaining_i    (remaining_o),
    .last_i         (last_o),
    .errors_o       (errors),
    .outstanding_o  (outstanding),
    .released_o     (n_released),
    .dropped_o      (n_dropped),
    .none_due_o     (n_none_due)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls at random, except in the calm stretch
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 36);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[timed_task_queue_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic op, input logic [TW-1:0] tv, input logic [GW-1:0] tg);
    if (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 36);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    time_value_i <= tv;
    task_tag_i   <= tg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  // hold the sender off until every predicted result word has been taken
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [TW-1:0] now_t;
    logic [TW-1:0] due;
    int            burst;
    int            random_sent;
    int            next_drain;

    now_t       = 32'd1000;
    random_sent = 0;
    next_drain  = 80;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue answers none due; the tag of a run word is ignored
    send_word(OP_RUN, '0, 8'hA5);
    send_word(OP_SCHEDULE, '0, 8'h00);
    send_word(OP_RUN, '0, 8'h5A);          // strict compare: due 0 not below 0
    send_word(OP_RUN, 32'd1, 8'h00);
    // equal due times leave in scheduling order
    send_word(OP_SCHEDULE, 32'd100, 8'h01);
    send_word(OP_SCHEDULE, 32'd100, 8'h02);
    send_word(OP_SCHEDULE, 32'd50, 8'h04);
    send_word(OP_SCHEDULE, 32'd100, 8'h03);
    send_word(OP_RUN, 32'd100, 8'h00);
    send_word(OP_RUN, 32'd101, 8'h00);
    // fill in descending order so each insert shifts the whole row, then overflow
    for (int i = 0; i < DEPTH_DEF; i++) begin
      if (i == 0) send_word(OP_SCHEDULE, 32'hFFFF_FFFE, 8'hFF);
      else send_word(OP_SCHEDULE, 32'h0000_1000 + TW'(DEPTH_DEF - i), 8'h10 + GW'(i));
    end
    send_word(OP_SCHEDULE, 32'd7, 8'hEE);
    send_word(OP_RUN, 32'hFFFF_FFFF, 8'h00);

    wait_drained();

    while (random_sent < RANDOM_WORDS) begin
      if ($urandom_range(99) < 80) begin
        // schedule burst followed by a run at an advancing clock
        burst = ($urandom_range(99) < 10) ? $urandom_range(12, 20) : $urandom_range(0, 8);
        repeat (burst) begin
          case ($urandom_range(9))
            0:       due = $urandom;
            1:       due = now_t - TW'($urandom_range(0, 20));
            default: due = now_t + TW'($urandom_range(0, 24));
          endcase
          send_word(OP_SCHEDULE, due, GW'($urandom));
          random_sent++;
        end
        now_t = now_t + TW'($urandom_range(0, 40));
        send_word(OP_RUN, now_t, GW'($urandom));
        random_sent++;
      end else begin
        send_word(1'($urandom), $urandom, GW'($urandom));
        random_sent++;
      end
      calm = (random_sent >= 120 && random_sent < 190);
      if (random_sent >= next_drain) begin
        wait_drained();
        next_drain += 80;
      end
    end

    // an entry due at the top of the time range can never be released
    send_word(OP_RUN, 32'hFFFF_FFFF, 8'h00);
    send_word(OP_SCHEDULE, 32'hFFFF_FFFF, 8'hC3);
    send_word(OP_RUN, 32'hFFFF_FFFF, 8'h3C);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Summary: %0d words sent (directed and random), %0d tasks released,",
             words_sent, n_released);
    $display("         %0d schedules dropped on a full queue, %0d none-due answers",
             n_dropped, n_none_due);
    if (errors == 0) $display("[timed_task_queue_core] OK");
    else $display("[timed_task_queue_core] ERROR");
    $finish;
  end

endmodule
